// ===== hdl/tnorm_pkg.sv =====
// ----------------------------------------------------------------------------
// tnorm_pkg: shared types and constants for the text normalizer stream
// Request structs for both channels, the queue entry passed from the front
// end to the back end, queue status, and the character codes used.
// ----------------------------------------------------------------------------
package tnorm_pkg;

	// Depth of the command queue between the front and the back end.
	localparam int QUEUE_DEPTH = 4;

	// Character codes.
	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_BANG     = 8'h21;
	localparam logic [7:0] CH_LPAREN   = 8'h28;
	localparam logic [7:0] CH_RPAREN   = 8'h29;
	localparam logic [7:0] CH_HYPHEN   = 8'h2D;
	localparam logic [7:0] CH_PERIOD   = 8'h2E;
	localparam logic [7:0] CH_QUESTION = 8'h3F;
	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
	localparam logic [7:0] CH_LOWER_A  = 8'h61;
	localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'd32;

	// Input request: one raw text byte.
	typedef struct packed {
		logic [7:0] char_in;
		logic       last_in;
	} in_req_t;

	// Output request: one normalized byte or the end marker.
	typedef struct packed {
		logic [7:0]  char_out;
		logic        end_marker;
		logic [31:0] total_length;
		logic        last_out;
	} out_req_t;

	// Command for the back end: which results one input byte causes.
	typedef struct packed {
		logic        emit_space;
		logic        emit_char;
		logic        emit_end;
		logic [7:0]  char_val;
		logic [31:0] total_length;
	} cmd_t;

	// Queue status seen by both ends.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== hdl/tnorm_front.sv =====
// ----------------------------------------------------------------------------
// tnorm_front: input classifier
// Accepts raw bytes, maps them to their normalized class, keeps the spacing
// and period state and the emitted byte count, and pushes one command per
// byte that causes any result.
// ----------------------------------------------------------------------------
module tnorm_front #(
	parameter int COUNT_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  tnorm_pkg::in_req_t  src_req,
	input  tnorm_pkg::q_status_t q_status,
	output logic                push,
	output tnorm_pkg::cmd_t     push_cmd
);
	import tnorm_pkg::*;

	localparam int EXT_BITS = (COUNT_BITS > 32) ? COUNT_BITS : 33;

	logic                  space_pending_q, after_period_q, joining_hyphen_q, at_text_start_q;
	logic [COUNT_BITS-1:0] emitted_count_q;

	logic                  space_pending_n, after_period_n, joining_hyphen_n, at_text_start_n;
	logic [COUNT_BITS-1:0] emitted_count_n;
	logic [COUNT_BITS-1:0] count_sum;
	logic [COUNT_BITS:0]   count_wide;
	logic [EXT_BITS-1:0]   count_ext;
	logic [31:0]           total_len;
	logic [1:0]            inc;
	logic [7:0]            c;
	logic                  accept;
	cmd_t                  cmd;

	// The queue full flag is the only source of back pressure.
	assign src_stall = q_status.full;
	assign accept    = src_valid && !src_stall;

	// Map the raw byte to its normalized class.
	always_comb begin
		c = src_req.char_in;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			c = c + CASE_OFFSET;
		end else if (c == CH_NEWLINE || c == CH_LPAREN || c == CH_RPAREN) begin
			c = CH_SPACE;
		end else if (c == CH_QUESTION || c == CH_BANG) begin
			c = CH_PERIOD;
		end
	end

	// Decide the results and the next spacing state.
	always_comb begin
		space_pending_n  = space_pending_q;
		after_period_n   = after_period_q;
		joining_hyphen_n = joining_hyphen_q;
		at_text_start_n  = at_text_start_q;
		cmd              = '0;
		cmd.emit_end     = src_req.last_in;
		priority if (c == CH_HYPHEN) begin
			joining_hyphen_n = 1'b1;
		end else if (joining_hyphen_q && c == CH_SPACE) begin
			// A space after a hyphen is skipped so the broken word joins.
		end else if (c == CH_PERIOD && !after_period_q) begin
			space_pending_n  = 1'b0;
			cmd.emit_char    = 1'b1;
			cmd.char_val     = CH_PERIOD;
			after_period_n   = 1'b1;
			at_text_start_n  = 1'b0;
			joining_hyphen_n = 1'b0;
		end else if (c == CH_SPACE && !(space_pending_q || at_text_start_q) &&
				!after_period_q) begin
			space_pending_n = 1'b1;
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			cmd.emit_space   = space_pending_q;
			cmd.emit_char    = 1'b1;
			cmd.char_val     = c;
			space_pending_n  = 1'b0;
			after_period_n   = 1'b0;
			at_text_start_n  = 1'b0;
			joining_hyphen_n = 1'b0;
		end else begin
			// Any other byte is dropped and leaves the state alone.
		end
	end

	// Saturating byte count and the 32-bit length for the end marker.
	always_comb begin
		inc        = {1'b0, cmd.emit_space} + {1'b0, cmd.emit_char};
		count_wide = {1'b0, emitted_count_q} + (COUNT_BITS + 1)'(inc);
		count_sum  = count_wide[COUNT_BITS] ? '1 : count_wide[COUNT_BITS-1:0];
		count_ext  = EXT_BITS'(count_sum);
		total_len  = (|count_ext[EXT_BITS-1:32]) ? 32'hFFFF_FFFF : count_ext[31:0];
		emitted_count_n = count_sum;
	end

	// Only bytes that cause a result occupy the queue.
	assign push = accept && (cmd.emit_space || cmd.emit_char || cmd.emit_end);

	// The queued command carries the length as of this byte.
	always_comb begin
		push_cmd              = cmd;
		push_cmd.total_length = total_len;
	end

	// State update; the last byte returns everything to the start of a text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_pending_q  <= 1'b0;
			after_period_q   <= 1'b0;
			joining_hyphen_q <= 1'b0;
			at_text_start_q  <= 1'b1;
			emitted_count_q  <= '0;
		end else if (accept) begin
			if (src_req.last_in) begin
				space_pending_q  <= 1'b0;
				after_period_q   <= 1'b0;
				joining_hyphen_q <= 1'b0;
				at_text_start_q  <= 1'b1;
				emitted_count_q  <= '0;
			end else begin
				space_pending_q  <= space_pending_n;
				after_period_q   <= after_period_n;
				joining_hyphen_q <= joining_hyphen_n;
				at_text_start_q  <= at_text_start_n;
				emitted_count_q  <= emitted_count_n;
			end
		end
	end

	// A pending space never coexists with a trailing period or the text start.
	a_space_excl: assert property (@(posedge clk) disable iff (!arst_n)
		space_pending_q |-> !after_period_q && !at_text_start_q)
		else $error("pending space together with period or text start");

	// After the last byte the next text starts clean.
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && src_req.last_in |=> at_text_start_q && !space_pending_q &&
			emitted_count_q == '0)
		else $error("state not reset after last byte");

endmodule

// ===== hdl/tnorm_queue.sv =====
// ----------------------------------------------------------------------------
// tnorm_queue: command queue
// A short register FIFO between the front and the back end so that each
// side can stall on its own.
// ----------------------------------------------------------------------------
module tnorm_queue #(
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tnorm_pkg::cmd_t       push_cmd,
	input  logic                  pop,
	output tnorm_pkg::cmd_t       head,
	output tnorm_pkg::q_status_t  q_status
);
	import tnorm_pkg::*;

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	cmd_t                entries_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] fill_q;
	logic                do_push, do_pop;

	assign q_status.full  = (fill_q == CNT_BITS'(DEPTH));
	assign q_status.empty = (fill_q == '0);
	assign do_push        = push && !q_status.full;
	assign do_pop         = pop && !q_status.empty;
	assign head           = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// A push is never dropped: the front end only pushes into free space.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("push into full queue");

endmodule

// ===== hdl/tnorm_back.sv =====
// ----------------------------------------------------------------------------
// tnorm_back: result sequencer
// Takes the command at the queue head apart into its results (pending space,
// byte, end marker), one per cycle while dst is not stalled, into the output register.
// ----------------------------------------------------------------------------
module tnorm_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tnorm_pkg::cmd_t       head,
	input  tnorm_pkg::q_status_t  q_status,
	output logic                  pop,
	output logic                  dst_valid,
	input  logic                  dst_stall,
	output tnorm_pkg::out_req_t   dst_req
);
	import tnorm_pkg::*;

	logic [2:0] done_q;
	logic       out_valid_q;
	out_req_t   out_q;

	logic [2:0] pend, pick, rest;
	logic       load_ok, step;
	out_req_t   result;

	// Results of the head command not yet sent; bit 0 space, 1 byte, 2 end.
	assign pend    = {head.emit_end, head.emit_char, head.emit_space} & ~done_q;
	assign load_ok = !out_valid_q || !dst_stall;
	assign step    = load_ok && !q_status.empty;

	// Pick the next result in output order and build it.
	always_comb begin
		result = '0;
		priority if (pend[0]) begin
			pick            = 3'b001;
			result.char_out = CH_SPACE;
		end else if (pend[1]) begin
			pick            = 3'b010;
			result.char_out = head.char_val;
		end else begin
			pick                = 3'b100;
			result.char_out     = CH_NUL;
			result.end_marker   = 1'b1;
			result.total_length = head.total_length;
			result.last_out     = 1'b1;
		end
		rest = pend & ~pick;
	end

	// The command leaves the queue with its final result.
	assign pop = step && (rest == 3'b000);

	// Control: output valid and the per-command progress mask.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_q      <= 3'b000;
		end else if (step) begin
			out_valid_q <= 1'b1;
			done_q      <= pop ? 3'b000 : (done_q | pick);
		end else if (load_ok) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= result;
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_req   = out_q;

	// Every queued command still has a result to send when it is served.
	a_pend_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> pend != 3'b000)
		else $error("served command with nothing left to send");

	// An end marker carries no byte and closes the run; bytes carry no length.
	a_marker_shape: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> (dst_req.end_marker ? (dst_req.last_out && dst_req.char_out == CH_NUL)
			: (!dst_req.last_out && dst_req.total_length == 32'd0)))
		else $error("malformed result");

endmodule

// ===== hdl/text_normalizer_stream.sv =====
// ----------------------------------------------------------------------------
// text_normalizer_stream: streaming text normalizer
// Lower-cases letters, folds spacing and punctuation, drops other bytes, and
// closes each text with an end marker carrying its saturated output length.
//
//   channel  direction  handshake             payload
//   src      in         src_valid/src_stall   in_req_t  (char_in, last_in)
//   dst      out        dst_valid/dst_stall   out_req_t (char_out, end_marker,
//                                                        total_length, last_out)
//
// One input byte is accepted per cycle while the command queue has room.
// The back end sends one result per cycle while dst is not stalled, so a byte
// with two or three results (pending space, byte, end marker) sends them in turn.
// Input reaches the output through the queue entry, then the output register.
// Reset is asynchronous; afterwards the block starts at the beginning of a text.
// A stall on dst fills the four-entry queue before src is stalled.
// ----------------------------------------------------------------------------
module text_normalizer_stream #(
	parameter int COUNT_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_stall,
	input  tnorm_pkg::in_req_t   src_req,
	output logic                 dst_valid,
	input  logic                 dst_stall,
	output tnorm_pkg::out_req_t  dst_req
);
	import tnorm_pkg::*;

	logic      push, pop;
	cmd_t      push_cmd, head;
	q_status_t q_status;

	// Front end: classification and spacing state.
	tnorm_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_req  (src_req),
		.q_status (q_status),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// Command queue between the two ends.
	tnorm_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.q_status(q_status)
	);

	// Back end: result sequencing and output register.
	tnorm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_req  (dst_req)
	);

endmodule
